[hdl/u2m_pkg.sv]
// Shared types, constants and lookup functions for the UTF-8 name to MacRoman converter.
// No dependencies; used by u2m_conv, u2m_fifo and utf8_name_to_macroman_unit.
`default_nettype none

package u2m_pkg;

	// register reset and output queue sizing
	localparam logic [7:0] MAX_LEN_RESET = 8'd63;
	localparam int MAX_RESULTS = 3;
	localparam int FIFO_DEPTH = 4;

	// character codes
	localparam logic [7:0] HIGH_BIT   = 8'h80;
	localparam logic [7:0] ASCII_COLON = 8'h3A;
	localparam logic [7:0] ASCII_SLASH = 8'h2F;
	localparam logic [7:0] LEAD_THREE = 8'hE2;

	// number of held bytes of a possible sequence
	localparam logic [1:0] PEND_NONE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_TWO  = 2'd2;

	typedef struct packed {
		logic [7:0] first_pending;
		logic [7:0] second_pending;
		logic [1:0] pending_count;
		logic [7:0] consumed_count;
		logic [7:0] emitted_count;
	} name_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_item_t;

	typedef struct packed {
		logic [1:0]                        count;
		out_item_t [MAX_RESULTS-1:0]       item;
	} conv_res_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] code;
	} lut_hit_t;

	// byte that opens some sequence of the table
	function automatic logic is_lead(input logic [7:0] b);
		return b inside {8'hC2, 8'hC3, 8'hC5, 8'hC6, 8'hCE, 8'hCF, 8'hE2};
	endfunction

	// first two bytes of a three-byte sequence
	function automatic logic prefix3(input logic [7:0] a, input logic [7:0] b);
		return (a == LEAD_THREE) && (b inside {8'h80, 8'h84, 8'h88, 8'h89, 8'h97});
	endfunction

	// colon maps to slash, all else passes
	function automatic logic [7:0] plain_char(input logic [7:0] b);
		return (b == ASCII_COLON) ? ASCII_SLASH : b;
	endfunction

	// two-byte sequences
	function automatic lut_hit_t match2(input logic [7:0] a, input logic [7:0] b);
		lut_hit_t r;
		r.hit = 1'b1;
		case ({a, b})
			16'hC384: r.code = 8'h80;
			16'hC385: r.code = 8'h81;
			16'hC387: r.code = 8'h82;
			16'hC389: r.code = 8'h83;
			16'hC391: r.code = 8'h84;
			16'hC396: r.code = 8'h85;
			16'hC39C: r.code = 8'h86;
			16'hC3A1: r.code = 8'h87;
			16'hC3A0: r.code = 8'h88;
			16'hC3A2: r.code = 8'h89;
			16'hC3A4: r.code = 8'h8A;
			16'hC3A3: r.code = 8'h8B;
			16'hC3A5: r.code = 8'h8C;
			16'hC3A7: r.code = 8'h8D;
			16'hC3A9: r.code = 8'h8E;
			16'hC3A8: r.code = 8'h8F;
			16'hC3AA: r.code = 8'h90;
			16'hC3AB: r.code = 8'h91;
			16'hC3AD: r.code = 8'h92;
			16'hC3AC: r.code = 8'h93;
			16'hC3AE: r.code = 8'h94;
			16'hC3AF: r.code = 8'h95;
			16'hC3B1: r.code = 8'h96;
			16'hC3B3: r.code = 8'h97;
			16'hC3B2: r.code = 8'h98;
			16'hC3B4: r.code = 8'h99;
			16'hC3B6: r.code = 8'h9A;
			16'hC3B5: r.code = 8'h9B;
			16'hC3BA: r.code = 8'h9C;
			16'hC3B9: r.code = 8'h9D;
			16'hC3BB: r.code = 8'h9E;
			16'hC3BC: r.code = 8'h9F;
			16'hC2B0: r.code = 8'hA1;
			16'hC2A2: r.code = 8'hA2;
			16'hC2A3: r.code = 8'hA3;
			16'hC2A7: r.code = 8'hA4;
			16'hC2B6: r.code = 8'hA6;
			16'hC39F: r.code = 8'hA7;
			16'hC2AE: r.code = 8'hA8;
			16'hC2A9: r.code = 8'hA9;
			16'hC2B4: r.code = 8'hAB;
			16'hC2A8: r.code = 8'hAC;
			16'hC386: r.code = 8'hAE;
			16'hC398: r.code = 8'hAF;
			16'hC2B1: r.code = 8'hB1;
			16'hC2A5: r.code = 8'hB4;
			16'hC2B5: r.code = 8'hB5;
			16'hCF80: r.code = 8'hB9;
			16'hC2AA: r.code = 8'hBB;
			16'hC2BA: r.code = 8'hBC;
			16'hCEA9: r.code = 8'hBD;
			16'hC3A6: r.code = 8'hBE;
			16'hC3B8: r.code = 8'hBF;
			16'hC2BF: r.code = 8'hC0;
			16'hC2A1: r.code = 8'hC1;
			16'hC2AC: r.code = 8'hC2;
			16'hC692: r.code = 8'hC4;
			16'hC2AB: r.code = 8'hC7;
			16'hC2BB: r.code = 8'hC8;
			16'hC2A0: r.code = 8'hCA;
			16'hC380: r.code = 8'hCB;
			16'hC383: r.code = 8'hCC;
			16'hC395: r.code = 8'hCD;
			16'hC592: r.code = 8'hCE;
			16'hC593: r.code = 8'hCF;
			16'hC3B7: r.code = 8'hD6;
			16'hC3BF: r.code = 8'hD8;
			default: begin
				r.hit  = 1'b0;
				r.code = 8'h00;
			end
		endcase
		return r;
	endfunction

	// three-byte sequences
	function automatic lut_hit_t match3(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		lut_hit_t r;
		r.hit = 1'b1;
		case ({a, b, c})
			24'hE280A0: r.code = 8'hA0;
			24'hE280A2: r.code = 8'hA5;
			24'hE284A2: r.code = 8'hAA;
			24'hE289A0: r.code = 8'hAD;
			24'hE2889E: r.code = 8'hB0;
			24'hE289A4: r.code = 8'hB2;
			24'hE289A5: r.code = 8'hB3;
			24'hE28882: r.code = 8'hB6;
			24'hE28891: r.code = 8'hB7;
			24'hE2888F: r.code = 8'hB8;
			24'hE288AB: r.code = 8'hBA;
			24'hE2889A: r.code = 8'hC3;
			24'hE28988: r.code = 8'hC5;
			24'hE28886: r.code = 8'hC6;
			24'hE280A6: r.code = 8'hC9;
			24'hE28093: r.code = 8'hD0;
			24'hE28094: r.code = 8'hD1;
			24'hE2809C: r.code = 8'hD2;
			24'hE2809D: r.code = 8'hD3;
			24'hE28098: r.code = 8'hD4;
			24'hE28099: r.code = 8'hD5;
			24'hE2978A: r.code = 8'hD7;
			default: begin
				r.hit  = 1'b0;
				r.code = 8'h00;
			end
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[hdl/u2m_conv.sv]
// Conversion logic for one item: sequence matching, pass-through and count item.
// Depends on u2m_pkg for the lookup functions and the state and result types.
`default_nettype none

module u2m_conv (
	input  wire u2m_pkg::name_state_t st,
	input  wire logic [7:0]           in_byte,
	input  wire logic                 end_of_name,
	input  wire logic [7:0]           max_length,
	output u2m_pkg::name_state_t      st_next,
	output u2m_pkg::conv_res_t        res
);

	always_comb begin
		u2m_pkg::lut_hit_t h2;
		u2m_pkg::lut_hit_t h3;
		logic              p3;
		logic [1:0]        npre;
		logic              tail;
		logic              seq_hit;
		logic [7:0]        seq_code;

		h2       = u2m_pkg::match2(st.first_pending, in_byte);
		h3       = u2m_pkg::match3(st.first_pending, st.second_pending, in_byte);
		p3       = u2m_pkg::prefix3(st.first_pending, in_byte);
		st_next  = st;
		res      = '0;
		npre     = 2'd0;
		tail     = 1'b0;
		seq_hit  = 1'b0;
		seq_code = h2.code;

		// decide what the held bytes and the new byte turn into
		if (end_of_name) begin
			case (st.pending_count)
				u2m_pkg::PEND_ONE: npre = 2'd1;
				u2m_pkg::PEND_TWO: npre = 2'd2;
				default:           npre = 2'd0;
			endcase
		end else if (st.consumed_count < max_length) begin
			st_next.consumed_count = st.consumed_count + 8'd1;
			st_next.pending_count  = u2m_pkg::PEND_NONE;
			case (st.pending_count)
				u2m_pkg::PEND_ONE: begin
					if (h2.hit) begin
						seq_hit  = 1'b1;
						seq_code = h2.code;
					end else if (p3) begin
						st_next.second_pending = in_byte;
						st_next.pending_count  = u2m_pkg::PEND_TWO;
					end else begin
						npre = 2'd1;
						tail = 1'b1;
					end
				end
				u2m_pkg::PEND_TWO: begin
					if (h3.hit) begin
						seq_hit  = 1'b1;
						seq_code = h3.code;
					end else begin
						npre = 2'd2;
						tail = 1'b1;
					end
				end
				default: tail = 1'b1;
			endcase
		end

		// held bytes go out raw, lead byte first
		res.item[0] = '{data: st.first_pending, last: 1'b0};
		res.item[1] = '{data: st.second_pending, last: 1'b0};
		res.count   = npre;
		if (seq_hit) begin
			res.item[0] = '{data: seq_code, last: 1'b0};
			res.count   = 2'd1;
		end

		// new byte starts afresh: hold a lead byte, pass anything else
		if (tail) begin
			if (in_byte >= u2m_pkg::HIGH_BIT && u2m_pkg::is_lead(in_byte)) begin
				st_next.first_pending = in_byte;
				st_next.pending_count = u2m_pkg::PEND_ONE;
			end else begin
				res.item[npre] = '{data: u2m_pkg::plain_char(in_byte), last: 1'b0};
				res.count      = npre + 2'd1;
			end
		end

		// close the name with its character count
		if (end_of_name) begin
			res.item[npre] = '{data: st.emitted_count + {6'd0, npre}, last: 1'b1};
			res.count      = npre + 2'd1;
			st_next        = '0;
		end else begin
			st_next.emitted_count = st.emitted_count + {6'd0, res.count};
		end
	end

endmodule

`default_nettype wire

[hdl/u2m_fifo.sv]
// Result queue: takes up to three items per cycle, hands out one per cycle.
// Depends on u2m_pkg for the item types and the result count.
`default_nettype none

module u2m_fifo #(
	parameter int DEPTH = u2m_pkg::FIFO_DEPTH
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire logic                    push,
	input  wire u2m_pkg::conv_res_t      push_res,
	input  wire logic                    pop,
	output logic                         room,
	output logic                         not_empty,
	output u2m_pkg::out_item_t           head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	u2m_pkg::out_item_t mem_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] wr_idx [u2m_pkg::MAX_RESULTS];
	logic [PW-1:0] wptr_next;
	logic [PW-1:0] rptr_next;
	logic [1:0]    push_n;

	assign push_n    = push ? push_res.count : 2'd0;
	assign room      = count_q <= CW'(DEPTH - u2m_pkg::MAX_RESULTS);
	assign not_empty = count_q != '0;
	assign head      = mem_q[rptr_q];

	// write slots and pointer advance, wrapped at the depth
	always_comb begin
		logic [PW:0] sum;
		for (int k = 0; k < u2m_pkg::MAX_RESULTS; k++) begin
			sum = {1'b0, wptr_q} + (PW+1)'(k);
			if (sum >= (PW+1)'(DEPTH)) sum = sum - (PW+1)'(DEPTH);
			wr_idx[k] = sum[PW-1:0];
		end
		sum = {1'b0, wptr_q} + (PW+1)'(push_n);
		if (sum >= (PW+1)'(DEPTH)) sum = sum - (PW+1)'(DEPTH);
		wptr_next = sum[PW-1:0];
		rptr_next = (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
	end

	// item storage
	always_ff @(posedge clk) begin
		for (int k = 0; k < u2m_pkg::MAX_RESULTS; k++) begin
			if (k < int'(push_n)) mem_q[wr_idx[k]] <= push_res.item[k];
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_next;
			if (pop) rptr_q <= rptr_next;
			count_q <= count_q + CW'(push_n) - CW'(pop);
		end
	end

endmodule

`default_nettype wire

[hdl/utf8_name_to_macroman_unit.sv]
// UTF-8 file name to MacRoman converter, top level.
// Byte stream in on s_*, characters and a closing count item out on m_*, limit on cfg_*.
// Depends on u2m_pkg, u2m_conv and u2m_fifo.
//
// Usage:
//   s_* carries one name byte per item in s_tdata; an item with s_tlast high carries
//   no byte and closes the name. m_* returns MacRoman characters, then one item with
//   m_tlast high whose m_tdata is the character count of the name.
//   cfg_* writes the byte limit per name (reset 63); write it only while idle.
// Flow:
//   an accepted item is held in the input register and is converted into the result
//   queue once the queue has room; its results then show on m_* in order. One item
//   per cycle is taken while each gives at most one result and m_* is not stalled; an
//   item giving two or three results takes as many queue slots, and the result queue
//   (depth OUT_DEPTH) drains one item a cycle while m_tready is high.
// Reset:
//   arst_n clears the pending bytes, counters, input register and queue, and sets the
//   limit to 63. When m_tready is low the queue fills and s_tready drops once fewer
//   than three slots are left and the input register holds an item; nothing is lost.
`default_nettype none

module utf8_name_to_macroman_unit #(
	parameter int OUT_DEPTH = u2m_pkg::FIFO_DEPTH
) (
	input  wire        clk,
	input  wire        arst_n,
	// name bytes in
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire  [7:0] s_tdata,    // [7:0] in_byte
	input  wire        s_tlast,    // end_of_name
	// characters and count out
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,    // [7:0] out_byte
	output logic       m_tlast,    // last
	// limit register
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire  [7:0] cfg_data    // [7:0] max_length
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 end_s1;
	logic [7:0]           max_len_q;
	u2m_pkg::name_state_t st_q;
	u2m_pkg::name_state_t st_next;
	u2m_pkg::conv_res_t   conv_res;
	u2m_pkg::out_item_t   head;
	logic                 room;
	logic                 advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && room;
	assign s_tready  = !valid_s1 || room;
	assign m_tdata   = head.data;
	assign m_tlast   = head.last;

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= u2m_pkg::MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	// input register control and name state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q     <= '0;
		end else begin
			if (s_tready) valid_s1 <= s_tvalid;
			if (advance) st_q <= st_next;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	u2m_conv u_conv (
		.st          (st_q),
		.in_byte     (byte_s1),
		.end_of_name (end_s1),
		.max_length  (max_len_q),
		.st_next     (st_next),
		.res         (conv_res)
	);

	u2m_fifo #(
		.DEPTH (OUT_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.push_res  (conv_res),
		.pop       (m_tvalid && m_tready),
		.room      (room),
		.not_empty (m_tvalid),
		.head      (head)
	);

endmodule

`default_nettype wire

[hdl/u2m_checker.sv]
// Port-level checks for utf8_name_to_macroman_unit, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module u2m_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       s_tready,
	input wire       m_tvalid,
	input wire       m_tready,
	input wire [7:0] m_tdata,
	input wire       m_tlast
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// input only backs up behind pending results
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output");

	// with the output stalled, a blocked input stays blocked
	a_stall_keep: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && !s_tready |=> !s_tready)
		else $error("input released while output stalled");

endmodule

bind utf8_name_to_macroman_unit u2m_checker u_u2m_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire

[tb/testbench.sv]
// Self-checking bench for utf8_name_to_macroman_unit: random and directed UTF-8 names
// go in on s_*, a scoreboard predicts the MacRoman characters and length items on m_*.
// Depends on u2m_pkg and the utf8_name_to_macroman_unit RTL.
`timescale 1ns / 1ps

module testbench;

	localparam int SEQ_ENTRIES    = 89;
	localparam int SQUEEZE_CYCLES = 150;
	localparam int STALL_LIMIT    = 1000;
	localparam int DRAIN_CYCLES   = 10;

	// utf-8 sequences and their MacRoman code: {byte0, byte1, byte2 (0 = none), code}
	localparam logic [31:0] SEQ_TABLE [0:SEQ_ENTRIES-1] = '{
		32'hC3840080, 32'hC3850081, 32'hC3870082, 32'hC3890083,
		32'hC3910084, 32'hC3960085, 32'hC39C0086, 32'hC3A10087,
		32'hC3A00088, 32'hC3A20089, 32'hC3A4008A, 32'hC3A3008B,
		32'hC3A5008C, 32'hC3A7008D, 32'hC3A9008E, 32'hC3A8008F,
		32'hC3AA0090, 32'hC3AB0091, 32'hC3AD0092, 32'hC3AC0093,
		32'hC3AE0094, 32'hC3AF0095, 32'hC3B10096, 32'hC3B30097,
		32'hC3B20098, 32'hC3B40099, 32'hC3B6009A, 32'hC3B5009B,
		32'hC3BA009C, 32'hC3B9009D, 32'hC3BB009E, 32'hC3BC009F,
		32'hE280A0A0, 32'hC2B000A1, 32'hC2A200A2, 32'hC2A300A3,
		32'hC2A700A4, 32'hE280A2A5, 32'hC2B600A6, 32'hC39F00A7,
		32'hC2AE00A8, 32'hC2A900A9, 32'hE284A2AA, 32'hC2B400AB,
		32'hC2A800AC, 32'hE289A0AD, 32'hC38600AE, 32'hC39800AF,
		32'hE2889EB0, 32'hC2B100B1, 32'hE289A4B2, 32'hE289A5B3,
		32'hC2A500B4, 32'hC2B500B5, 32'hE28882B6, 32'hE28891B7,
		32'hE2888FB8, 32'hCF8000B9, 32'hE288ABBA, 32'hC2AA00BB,
		32'hC2BA00BC, 32'hCEA900BD, 32'hC3A600BE, 32'hC3B800BF,
		32'hC2BF00C0, 32'hC2A100C1, 32'hC2AC00C2, 32'hE2889AC3,
		32'hC69200C4, 32'hE28988C5, 32'hE28886C6, 32'hC2AB00C7,
		32'hC2BB00C8, 32'hE280A6C9, 32'hC2A000CA, 32'hC38000CB,
		32'hC38300CC, 32'hC39500CD, 32'hC59200CE, 32'hC59300CF,
		32'hE28093D0, 32'hE28094D1, 32'hE2809CD2, 32'hE2809DD3,
		32'hE28098D4, 32'hE28099D5, 32'hC3B700D6, 32'hE2978AD7,
		32'hC3BF00D8
	};

	typedef enum {MATCH_PAIR, PREFIX_TRIPLE, MATCH_TRIPLE} seq_kind_t;

	typedef struct packed {
		logic [7:0] code;
		logic       is_count;
	} name_result_t;

	// predicts the converted name and compares what comes out
	class macroman_scoreboard;
		logic [7:0]   limit;
		logic [7:0]   lead_byte;
		logic [7:0]   mid_byte;
		logic [1:0]   held;
		logic [7:0]   bytes_taken;
		logic [7:0]   chars_out;
		int           step_emits;
		int           errors;
		name_result_t expected_chars [$];

		function new();
			limit  = u2m_pkg::MAX_LEN_RESET;
			errors = 0;
			clear_name();
		endfunction

		function void clear_name();
			lead_byte   = 8'h00;
			mid_byte    = 8'h00;
			held        = u2m_pkg::PEND_NONE;
			bytes_taken = 8'h00;
			chars_out   = 8'h00;
		endfunction

		function void set_limit(logic [7:0] v);
			limit = v;
		endfunction

		function int outstanding();
			return expected_chars.size();
		endfunction

		function logic [7:0] to_plain(logic [7:0] b);
			return (b == u2m_pkg::ASCII_COLON) ? u2m_pkg::ASCII_SLASH : b;
		endfunction

		function bit starts_seq(logic [7:0] b);
			for (int i = 0; i < SEQ_ENTRIES; i++)
				if (SEQ_TABLE[i][31:24] == b) return 1'b1;
			return 1'b0;
		endfunction

		// index of the table entry that fits, or -1
		function int find_seq(seq_kind_t kind, logic [7:0] a, logic [7:0] b, logic [7:0] c);
			logic [7:0] third;
			for (int i = 0; i < SEQ_ENTRIES; i++) begin
				if (SEQ_TABLE[i][31:24] != a || SEQ_TABLE[i][23:16] != b) continue;
				third = SEQ_TABLE[i][15:8];
				case (kind)
					MATCH_PAIR:    if (third == 8'h00) return i;
					PREFIX_TRIPLE: if (third != 8'h00) return i;
					MATCH_TRIPLE:  if (third != 8'h00 && third == c) return i;
					default: ;
				endcase
			end
			return -1;
		endfunction

		function void push_result(logic [7:0] v, logic is_count);
			name_result_t r;
			if (step_emits >= u2m_pkg::MAX_RESULTS) return;
			r.code     = v;
			r.is_count = is_count;
			expected_chars.push_back(r);
			step_emits++;
			if (!is_count) chars_out = chars_out + 8'd1;
		endfunction

		// one byte through the sequence matcher
		function void take_byte(logic [7:0] b);
			int k;
			if (held == u2m_pkg::PEND_ONE) begin
				k = find_seq(MATCH_PAIR, lead_byte, b, 8'h00);
				if (k >= 0) begin
					held = u2m_pkg::PEND_NONE;
					push_result(SEQ_TABLE[k][7:0], 1'b0);
					return;
				end
				if (find_seq(PREFIX_TRIPLE, lead_byte, b, 8'h00) >= 0) begin
					mid_byte = b;
					held     = u2m_pkg::PEND_TWO;
					return;
				end
				// lead goes out raw, the byte starts over
				held = u2m_pkg::PEND_NONE;
				push_result(lead_byte, 1'b0);
				take_byte(b);
				return;
			end
			if (held == u2m_pkg::PEND_TWO) begin
				k = find_seq(MATCH_TRIPLE, lead_byte, mid_byte, b);
				if (k >= 0) begin
					held = u2m_pkg::PEND_NONE;
					push_result(SEQ_TABLE[k][7:0], 1'b0);
					return;
				end
				held = u2m_pkg::PEND_NONE;
				push_result(lead_byte, 1'b0);
				take_byte(mid_byte);
				take_byte(b);
				return;
			end
			held = u2m_pkg::PEND_NONE;
			if (b >= u2m_pkg::HIGH_BIT && starts_seq(b)) begin
				lead_byte = b;
				held      = u2m_pkg::PEND_ONE;
			end else begin
				push_result(to_plain(b), 1'b0);
			end
		endfunction

		// accepted input item
		function void note_input(logic [7:0] b, logic end_of_name);
			step_emits = 0;
			if (!end_of_name) begin
				if (bytes_taken >= limit) return;
				bytes_taken = bytes_taken + 8'd1;
				take_byte(b);
				return;
			end
			// flush held bytes, then the length item
			if (held == u2m_pkg::PEND_ONE || held == u2m_pkg::PEND_TWO) begin
				push_result(lead_byte, 1'b0);
				if (held == u2m_pkg::PEND_TWO)
					push_result((mid_byte >= u2m_pkg::HIGH_BIT) ? mid_byte : to_plain(mid_byte),
						1'b0);
			end
			push_result(chars_out, 1'b1);
			clear_name();
		endfunction

		// accepted output item
		function void check_result(logic [7:0] code, logic is_count);
			name_result_t exp_r;
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected item, expected none, actual data %02h last %0b",
					$time, code, is_count);
				errors++;
				return;
			end
			exp_r = expected_chars.pop_front();
			if (code !== exp_r.code) begin
				$display("%0t: out_byte mismatch, expected %02h, actual %02h",
					$time, exp_r.code, code);
				errors++;
			end
			if (is_count !== exp_r.is_count) begin
				$display("%0t: last mismatch, expected %0b, actual %0b",
					$time, exp_r.is_count, is_count);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;     // [7:0] in_byte
	logic       s_tlast;     // end_of_name
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;     // [7:0] out_byte
	logic       m_tlast;     // last
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;

	macroman_scoreboard sb;
	int  tx_idle_pct;
	int  rx_idle_pct;
	int  sent_items;
	int  quiet_cycles;
	bit  squeeze_req;
	bit  squeeze_done;

	utf8_name_to_macroman_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predict on every accepted input item, check every accepted output item
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (s_tvalid && s_tready) sb.note_input(s_tdata, s_tlast);
			if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast);
		end
	end

	// watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// receiver: random back-pressure plus one long hold-off on request
	initial begin
		int stall;
		m_tready     = 1'b0;
		squeeze_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (squeeze_req && !squeeze_done) begin
				m_tready <= 1'b0;
				for (stall = 0; stall < SQUEEZE_CYCLES; stall++) @(posedge clk);
				squeeze_done = 1'b1;
			end
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	task automatic send_item(input logic [7:0] b, input logic end_of_name);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= end_of_name;
		do @(posedge clk); while (!s_tready);
		sent_items++;
	endtask

	// name bytes, then the closing item with junk in the byte field
	task automatic send_text(input logic [7:0] name [$]);
		foreach (name[i]) send_item(name[i], 1'b0);
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic send_random_name(input int tokens);
		logic [7:0]  name [$];
		logic [31:0] entry;
		int          pick;
		for (int t = 0; t < tokens; t++) begin
			pick  = $urandom_range(0, 99);
			entry = SEQ_TABLE[$urandom_range(0, SEQ_ENTRIES - 1)];
			if (pick < 40) begin
				// whole table sequence
				name.push_back(entry[31:24]);
				name.push_back(entry[23:16]);
				if (entry[15:8] != 8'h00) name.push_back(entry[15:8]);
			end else if (pick < 70) begin
				name.push_back(($urandom_range(0, 9) == 0) ? u2m_pkg::ASCII_COLON :
					8'($urandom_range(8'h20, 8'h7E)));
			end else if (pick < 82) begin
				name.push_back(8'($urandom_range(0, 255)));
			end else begin
				// sequence cut short
				name.push_back(entry[31:24]);
				if (entry[15:8] != 8'h00 && $urandom_range(0, 1) == 1)
					name.push_back(entry[23:16]);
			end
		end
		send_text(name);
	endtask

	task automatic run_names(input int budget);
		int target;
		target = sent_items + budget;
		while (sent_items < target) send_random_name($urandom_range(1, 12));
	endtask

	// limit write once everything expected is out and the pipeline is quiet
	task automatic write_limit(input logic [7:0] v);
		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_limit(v);
	endtask

	initial begin
		logic [7:0] name [$];
		sb          = new();
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = 8'h00;
		s_tlast     = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = 8'h00;
		tx_idle_pct = 11;
		rx_idle_pct = 11;
		sent_items  = 0;
		quiet_cycles = 0;
		squeeze_req = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed names at the reset limit
		// plain ascii, colon to slash, zero byte and 0xff pass through
		name = {8'h41, 8'h3A, 8'h00, 8'hFF};
		send_text(name);
		// two-byte and three-byte table hits
		name = {8'hC3, 8'h84, 8'hE2, 8'h80, 8'hA0};
		send_text(name);
		// unmatched lead, then broken three-byte sequence
		name = {8'hC3, 8'h41, 8'hE2, 8'h80, 8'h41};
		send_text(name);
		// two held bytes flushed at the end
		name = {8'hE2, 8'h80};
		send_text(name);
		// one held byte flushed at the end
		name = {8'hC3};
		send_text(name);
		// empty name
		name = {};
		send_text(name);

		// limit of one: lead kept, its partner ignored past the limit
		write_limit(8'd1);
		name = {8'hC3, 8'h84};
		send_text(name);
		run_names(20);

		// largest limit, no idling, receiver holds off while names keep coming
		write_limit(8'd255);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		squeeze_req = 1'b1;
		run_names(60);
		tx_idle_pct = 11;
		rx_idle_pct = 11;

		// short limits that cut sequences
		write_limit(8'($urandom_range(2, 8)));
		run_names(60);

		write_limit(8'($urandom_range(9, 254)));
		run_names(60);

		s_tvalid <= 1'b0;
		while (sb.outstanding() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
